@@ hdl/kmps_pkg.sv @@
// Package for the k-mismatch pattern search block.
// Shared sizes, codes and types; no dependencies.
package kmps_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int SYMBOL_BITS = 8;
    localparam int CELL_W      = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 7;
    localparam int POS_W       = 32;
    localparam int IDX_W       = 6;
    localparam int GROUP       = 8;
    localparam int NGROUP      = (PATTERN_MAX + GROUP - 1) / GROUP;
    localparam int GRP_W       = $clog2(GROUP + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    typedef logic [SYMBOL_BITS-1:0] t_sym;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 1'b0,
        CFG_MAX_MISMATCHES = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_PATTERN = 1'b0,
        OP_TEXT    = 1'b1
    } t_op;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic adv;     // pipeline advances
        logic shift;   // text symbol enters the window
        logic rotate;  // pattern ring steps one cell up
    } t_cell_ctl;

endpackage

@@ hdl/kmps_in_if.sv @@
// Input channel of the k-mismatch pattern search: valid/ready plus item payload.
// Depends on kmps_pkg.
interface kmps_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic                        first_of_text;
    logic [kmps_pkg::IDX_W-1:0]  pattern_index;
    kmps_pkg::t_sym              symbol;

    modport source (output valid, operation, first_of_text, pattern_index, symbol,
                    input ready);
    modport sink   (input valid, operation, first_of_text, pattern_index, symbol,
                    output ready);
endinterface

@@ hdl/kmps_out_if.sv @@
// Result channel of the k-mismatch pattern search: valid/ready plus result payload.
// Depends on kmps_pkg.
interface kmps_out_if;
    logic                        valid;
    logic                        ready;
    logic [kmps_pkg::POS_W-1:0]  match_start;
    logic [kmps_pkg::CNT_W-1:0]  mismatch_count;

    modport source (output valid, match_start, mismatch_count, input ready);
    modport sink   (input valid, match_start, mismatch_count, output ready);
endinterface

@@ hdl/k_mismatch_pattern_search.sv @@
// Results pass r_v0, r_v1, r_v2 and r_out_valid; one item per cycle when not stalled.
// Cell k holds window slot k (newest in cell 0) and the pattern symbol it must
// meet; after a pattern_length write the pattern ring realigns one cell per
// cycle, with input ready low until the ring is aligned.
// Reset sets length 1 and max mismatches 0 and clears the position counter and pipeline; pattern undefined.
// Uses kmps_pkg, kmps_in_if, kmps_out_if, kmps_cell, kmps_count.
module k_mismatch_pattern_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kmps_in_if.sink                           i_item,
    kmps_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [kmps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kmps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PM = kmps_pkg::PATTERN_MAX;

    logic [kmps_pkg::LEN_W-1:0]  r_plen;
    logic [kmps_pkg::CNT_W-1:0]  r_maxmm;
    logic [kmps_pkg::CELL_W-1:0] r_rot;
    logic [kmps_pkg::POS_W-1:0]  r_seen;
    logic                        r_v0, r_v1, r_v2;
    logic [kmps_pkg::POS_W-1:0]  r_start0, r_start1, r_start2;
    logic                        r_out_valid;
    logic [kmps_pkg::POS_W-1:0]  r_out_start;
    logic [kmps_pkg::CNT_W-1:0]  r_out_cnt;

    logic [kmps_pkg::LEN_W-1:0]  p_used;
    logic [kmps_pkg::CELL_W-1:0] rot_target;
    logic                        aligned;
    logic                        en;
    logic                        acc, txt_acc, pat_acc;
    logic [kmps_pkg::POS_W-1:0]  seen_base;
    logic [kmps_pkg::POS_W-1:0]  n_seen;
    logic                        v0_in;
    logic [kmps_pkg::CELL_W-1:0] wr_cell;
    logic [kmps_pkg::CNT_W-1:0]  total;
    kmps_pkg::t_cell_ctl         ctl;

    kmps_pkg::t_sym              txt [PM];
    kmps_pkg::t_sym              pat [PM];
    logic [PM-1:0]               mis;

    assign p_used = (r_plen > kmps_pkg::LEN_W'(PM)) ? kmps_pkg::LEN_W'(PM) : r_plen;
    // Cell k holds pattern[(r_rot - k) mod PATTERN_MAX]; aligned when r_rot = p-1 or p = 0
    assign rot_target = kmps_pkg::CELL_W'(p_used - kmps_pkg::LEN_W'(1));
    assign aligned    = (r_rot == rot_target) || (p_used == '0);

    assign en           = !r_out_valid || o_result.ready;
    assign i_item.ready = en && aligned;
    assign acc     = i_item.valid && i_item.ready;
    assign txt_acc = acc && (kmps_pkg::t_op'(i_item.operation) == kmps_pkg::OP_TEXT);
    assign pat_acc = acc && (kmps_pkg::t_op'(i_item.operation) == kmps_pkg::OP_PATTERN);

    assign seen_base = i_item.first_of_text ? '0 : r_seen;
    assign n_seen    = (seen_base == '1) ? seen_base : seen_base + kmps_pkg::POS_W'(1);
    assign v0_in     = txt_acc && (p_used != '0)
                       && (n_seen >= kmps_pkg::POS_W'(p_used));
    assign wr_cell   = r_rot - kmps_pkg::CELL_W'(i_item.pattern_index);

    assign ctl.adv    = en;
    assign ctl.shift  = txt_acc;
    assign ctl.rotate = !aligned;

    for (genvar k = 0; k < PM; k++) begin : g_cell
        kmps_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_txt_prev ((k == 0) ? i_item.symbol : txt[(k + PM - 1) % PM]),
            .i_pat_prev (pat[(k + PM - 1) % PM]),
            .i_sym      (i_item.symbol),
            .i_pat_we   (pat_acc && (wr_cell == kmps_pkg::CELL_W'(k))),
            .i_live     (p_used > kmps_pkg::LEN_W'(k)),
            .o_txt      (txt[k]),
            .o_pat      (pat[k]),
            .o_mis      (mis[k])
        );
    end

    kmps_count u_count (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mis   (mis),
        .o_total (total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= kmps_pkg::LEN_W'(1);
            r_maxmm     <= '0;
            r_rot       <= '0;
            r_seen      <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (kmps_pkg::t_cfg_idx'(i_cfg_index))
                    kmps_pkg::CFG_PATTERN_LENGTH: begin
                        r_plen <= i_cfg_data;
                    end
                    kmps_pkg::CFG_MAX_MISMATCHES: begin
                        r_maxmm <= i_cfg_data;
                    end
                endcase
            end
            if (!aligned) begin
                r_rot <= r_rot + kmps_pkg::CELL_W'(1);
            end
            if (txt_acc) begin
                r_seen <= n_seen;
            end
            if (en) begin
                r_v0        <= v0_in;
                r_v1        <= r_v0;
                r_v2        <= r_v1;
                r_out_valid <= r_v2 && (total <= r_maxmm);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_start0    <= n_seen - kmps_pkg::POS_W'(p_used);
            r_start1    <= r_start0;
            r_start2    <= r_start1;
            r_out_start <= r_start2;
            r_out_cnt   <= total;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.match_start    = r_out_start;
    assign o_result.mismatch_count = r_out_cnt;

endmodule

@@ hdl/kmps_cell.sv @@
// One cell of the search chain: a text window slot, a pattern ring slot and
// a registered mismatch flag. Depends on kmps_pkg.
module kmps_cell (
    input  logic                i_clk,
    input  kmps_pkg::t_cell_ctl i_ctl,
    input  kmps_pkg::t_sym      i_txt_prev,
    input  kmps_pkg::t_sym      i_pat_prev,
    input  kmps_pkg::t_sym      i_sym,
    input  logic                i_pat_we,
    input  logic                i_live,
    output kmps_pkg::t_sym      o_txt,
    output kmps_pkg::t_sym      o_pat,
    output logic                o_mis
);

    kmps_pkg::t_sym r_txt;
    kmps_pkg::t_sym r_pat;
    logic           r_mis;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_txt <= i_txt_prev;
        end
        if (i_ctl.rotate) begin
            r_pat <= i_pat_prev;
        end else if (i_pat_we) begin
            r_pat <= i_sym;
        end
        if (i_ctl.adv) begin
            r_mis <= i_live && (r_txt != r_pat);
        end
    end

    assign o_txt = r_txt;
    assign o_pat = r_pat;
    assign o_mis = r_mis;

endmodule

@@ hdl/kmps_count.sv @@
// Two-level mismatch counter: registered group popcounts, then their sum.
// Depends on kmps_pkg.
module kmps_count (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [kmps_pkg::PATTERN_MAX-1:0] i_mis,
    output logic [kmps_pkg::CNT_W-1:0]    o_total
);

    logic [kmps_pkg::GRP_W-1:0] r_grp [kmps_pkg::NGROUP];
    logic [kmps_pkg::GRP_W-1:0] n_grp [kmps_pkg::NGROUP];

    always_comb begin
        for (int g = 0; g < kmps_pkg::NGROUP; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < kmps_pkg::GROUP; b++) begin
                if (g * kmps_pkg::GROUP + b < kmps_pkg::PATTERN_MAX) begin
                    n_grp[g] = n_grp[g]
                             + kmps_pkg::GRP_W'(i_mis[g * kmps_pkg::GROUP + b]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_total = '0;
        for (int g = 0; g < kmps_pkg::NGROUP; g++) begin
            o_total = o_total + kmps_pkg::CNT_W'(r_grp[g]);
        end
    end

endmodule

@@ hdl/kmps_checker.sv @@
// Port-level checks for the k-mismatch pattern search, bound to the top level.
// Depends on kmps_pkg and k_mismatch_pattern_search.
module kmps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [kmps_pkg::POS_W-1:0]  i_match_start,
    input logic [kmps_pkg::CNT_W-1:0]  i_mismatch_count
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_match_start) && $stable(i_mismatch_count))
        else $error("result payload changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_mismatch_count <= kmps_pkg::CNT_W'(kmps_pkg::PATTERN_MAX))
        else $error("mismatch count beyond window size");

endmodule

bind k_mismatch_pattern_search kmps_checker u_kmps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_match_start    (o_result.match_start),
    .i_mismatch_count (o_result.mismatch_count)
);

@@ sim/tb.sv @@
// Testbench for k_mismatch_pattern_search: directed table, then random texts against
// a Hamming-distance predictor. Depends on kmps_pkg, kmps_in_if, kmps_out_if and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int RAND_ITEMS     = 650;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is 4 deep
    localparam int DRAIN_CYCLES   = 16;
    localparam int SQUEEZE_CYCLES = 300;
    // longest quiet stretch: squeeze plus a sender gap, or a realign plus a stall
    localparam int IDLE_LIMIT     = 4000;

    typedef struct packed {
        kmps_pkg::t_op              op;
        logic                       first;
        logic [kmps_pkg::IDX_W-1:0] idx;
        kmps_pkg::t_sym             sym;
    } t_item;

    typedef struct packed {
        logic [kmps_pkg::POS_W-1:0] start;
        logic [kmps_pkg::CNT_W-1:0] cnt;
    } t_match;

    typedef enum logic [2:0] {
        ROW_PAT,   // pattern write
        ROW_TXT,   // text symbol, checked by the predictor
        ROW_HIT,   // text symbol with the match typed in
        ROW_NONE,  // text symbol that must not report
        ROW_LEN,   // pattern_length write
        ROW_MAX    // max_mismatches write
    } t_row_kind;

    // val holds the register value for ROW_LEN/ROW_MAX, the count for ROW_HIT
    typedef struct packed {
        t_row_kind                  kind;
        logic                       first;
        logic [kmps_pkg::IDX_W-1:0] idx;
        logic [kmps_pkg::CNT_W-1:0] val;
        kmps_pkg::t_sym             sym;
        logic [kmps_pkg::POS_W-1:0] start;
    } t_row;

    localparam int NDIR = 25;

    // Reset config is length 1, no mismatches allowed
    t_row dir_rows [NDIR] = '{
        '{ROW_PAT,  1'b1, 6'd0,  7'd0,   8'h00, 32'd0},  // first bit ignored on writes
        '{ROW_PAT,  1'b0, 6'd63, 7'd0,   8'hFF, 32'd0},
        '{ROW_HIT,  1'b1, 6'd0,  7'd0,   8'h00, 32'd0},
        '{ROW_NONE, 1'b0, 6'd0,  7'd0,   8'hFF, 32'd0},
        '{ROW_HIT,  1'b0, 6'd0,  7'd0,   8'h00, 32'd2},
        '{ROW_PAT,  1'b1, 6'd0,  7'd0,   8'hFF, 32'd0},  // window and position kept
        '{ROW_HIT,  1'b0, 6'd0,  7'd0,   8'hFF, 32'd3},
        '{ROW_HIT,  1'b1, 6'd0,  7'd0,   8'hFF, 32'd0},  // restart
        '{ROW_MAX,  1'b0, 6'd0,  7'd127, 8'h00, 32'd0},
        '{ROW_HIT,  1'b0, 6'd0,  7'd1,   8'h5A, 32'd1},
        '{ROW_LEN,  1'b0, 6'd0,  7'd0,   8'h00, 32'd0},  // length zero never reports
        '{ROW_NONE, 1'b0, 6'd0,  7'd0,   8'hFF, 32'd0},
        '{ROW_NONE, 1'b1, 6'd0,  7'd0,   8'hFF, 32'd0},
        '{ROW_LEN,  1'b0, 6'd0,  7'd2,   8'h00, 32'd0},
        '{ROW_PAT,  1'b0, 6'd1,  7'd0,   8'h3C, 32'd0},
        '{ROW_NONE, 1'b1, 6'd0,  7'd0,   8'hAA, 32'd0},  // window not yet full
        '{ROW_HIT,  1'b0, 6'd0,  7'd1,   8'h3C, 32'd0},
        '{ROW_MAX,  1'b0, 6'd0,  7'd0,   8'h00, 32'd0},
        '{ROW_TXT,  1'b0, 6'd0,  7'd0,   8'hFF, 32'd0},
        '{ROW_TXT,  1'b0, 6'd0,  7'd0,   8'h3C, 32'd0},
        '{ROW_TXT,  1'b1, 6'd0,  7'd0,   8'hFF, 32'd0},
        '{ROW_TXT,  1'b0, 6'd0,  7'd0,   8'h3C, 32'd0},
        '{ROW_MAX,  1'b0, 6'd0,  7'd64,  8'h00, 32'd0},
        '{ROW_LEN,  1'b0, 6'd0,  7'd127, 8'h00, 32'd0},  // saturates to PATTERN_MAX
        '{ROW_TXT,  1'b1, 6'd0,  7'd0,   8'h01, 32'd0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [kmps_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [kmps_pkg::CFG_DATA_W-1:0] i_cfg_data;

    kmps_in_if  in_ch ();
    kmps_out_if out_ch ();

    k_mismatch_pattern_search DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_ch),
        .o_result    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    kmps_pkg::t_sym                  pattern_shadow [kmps_pkg::PATTERN_MAX];
    kmps_pkg::t_sym                  window_shadow  [kmps_pkg::PATTERN_MAX];  // 0 is newest
    logic [kmps_pkg::POS_W-1:0]      seen_count;
    logic [kmps_pkg::CFG_DATA_W-1:0] len_shadow;
    logic [kmps_pkg::CFG_DATA_W-1:0] kmax_shadow;

    t_match pending_hits [$];
    int     mismatches   = 0;
    int     items_sent   = 0;
    int     idle_cycles  = 0;
    bit     burst        = 1'b0;
    bit     squeeze_go   = 1'b0;
    bit     squeeze_done = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one accepted transaction to the shadow state and work out its match
    task automatic hamming_step(input t_item it, output bit hit, output t_match m);
        int unsigned used;
        int unsigned diff;
        hit = 1'b0;
        m   = '0;
        if (it.op == kmps_pkg::OP_PATTERN) begin
            pattern_shadow[it.idx] = it.sym;
        end else begin
            if (it.first) begin
                foreach (window_shadow[i]) window_shadow[i] = '0;
                seen_count = '0;
            end
            for (int i = kmps_pkg::PATTERN_MAX - 1; i > 0; i--)
                window_shadow[i] = window_shadow[i-1];
            window_shadow[0] = it.sym;
            if (seen_count != '1) seen_count++;
            used = (len_shadow > kmps_pkg::PATTERN_MAX) ? kmps_pkg::PATTERN_MAX : len_shadow;
            if (used != 0 && seen_count >= used) begin
                diff = 0;
                for (int i = 0; i < used; i++)
                    if (window_shadow[used-1-i] != pattern_shadow[i]) diff++;
                if (diff <= kmax_shadow) begin
                    hit     = 1'b1;
                    m.start = seen_count - kmps_pkg::POS_W'(used);
                    m.cnt   = kmps_pkg::CNT_W'(diff);
                end
            end
        end
    endtask

    task automatic send_item(input t_item it, input bit typed, input bit want_hit,
                             input t_match want);
        bit     hit;
        t_match m;
        int     gap;
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= it.op;
        in_ch.first_of_text <= it.first;
        in_ch.pattern_index <= it.idx;
        in_ch.symbol        <= it.sym;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        hamming_step(it, hit, m);
        if (typed) begin
            hit = want_hit;
            m   = want;
        end
        if (hit) pending_hits = {pending_hits, m};
        items_sent++;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Register writes only once the pipeline has emptied
    task automatic write_reg(input kmps_pkg::t_cfg_idx r,
                             input logic [kmps_pkg::CFG_DATA_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (r == kmps_pkg::CFG_PATTERN_LENGTH) len_shadow = v;
        else kmax_shadow = v;
    endtask

    // One setting of the registers, then texts built mostly from mutated pattern copies
    task automatic run_phase(input int len_val, input int kmax_val, input int budget);
        int     eff;
        int     sent0;
        int     text_len;
        int     pos;
        int     r;
        int     mut_pct;
        bit     narrow;
        t_item  it;
        t_match none;
        none = '0;
        write_reg(kmps_pkg::CFG_PATTERN_LENGTH, kmps_pkg::CFG_DATA_W'(len_val));
        write_reg(kmps_pkg::CFG_MAX_MISMATCHES, kmps_pkg::CFG_DATA_W'(kmax_val));
        eff   = (len_val > kmps_pkg::PATTERN_MAX) ? kmps_pkg::PATTERN_MAX : len_val;
        burst = ($urandom_range(0, 3) == 0);
        sent0 = items_sent;
        if ($urandom_range(0, 1)) begin
            narrow = $urandom_range(0, 1);
            for (int i = 0; i < eff; i++) begin
                it.op    = kmps_pkg::OP_PATTERN;
                it.first = $urandom_range(0, 1);
                it.idx   = kmps_pkg::IDX_W'(i);
                it.sym   = narrow ? kmps_pkg::t_sym'($urandom_range(0, 3))
                                  : kmps_pkg::t_sym'($urandom);
                send_item(it, 1'b0, 1'b0, none);
            end
        end
        while (items_sent - sent0 < budget) begin
            text_len = eff + $urandom_range(1, 2 * eff + 8);
            pos      = 0;
            while (pos < text_len) begin
                r = $urandom_range(0, 99);
                if (r < 60 && eff > 0) begin
                    case ($urandom_range(0, 3))
                        0:       mut_pct = 0;
                        1:       mut_pct = 4;
                        2:       mut_pct = 15;
                        default: mut_pct = 40;
                    endcase
                    for (int i = 0; i < eff; i++) begin
                        it.op    = kmps_pkg::OP_TEXT;
                        it.first = (pos == 0);
                        it.idx   = kmps_pkg::IDX_W'($urandom);
                        it.sym   = ($urandom_range(0, 99) < mut_pct)
                                   ? kmps_pkg::t_sym'($urandom) : pattern_shadow[i];
                        send_item(it, 1'b0, 1'b0, none);
                        pos++;
                    end
                end else if (r < 96) begin
                    it.op    = kmps_pkg::OP_TEXT;
                    it.first = (pos == 0) || ($urandom_range(0, 63) == 0);
                    it.idx   = kmps_pkg::IDX_W'($urandom);
                    if (eff > 0 && $urandom_range(0, 1))
                        it.sym = pattern_shadow[$urandom_range(0, eff - 1)];
                    else
                        it.sym = kmps_pkg::t_sym'($urandom);
                    send_item(it, 1'b0, 1'b0, none);
                    pos++;
                end else begin
                    // pattern rewrite in the middle of a text
                    it.op    = kmps_pkg::OP_PATTERN;
                    it.first = $urandom_range(0, 1);
                    it.idx   = kmps_pkg::IDX_W'($urandom);
                    it.sym   = kmps_pkg::t_sym'($urandom);
                    send_item(it, 1'b0, 1'b0, none);
                end
            end
        end
    endtask

    task automatic log_mismatch(input string what, input t_match want, input t_match got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected start=%0d count=%0d, got start=%0d count=%0d",
                     $time, what, want.start, want.cnt, got.start, got.cnt);
    endtask

    initial begin : stim
        t_row   row;
        t_item  it;
        t_match want;
        int     phase;
        int     plen;
        int     kmax;
        int     budget;
        int     rand_base;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_data          <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.operation     <= 1'b0;
        in_ch.first_of_text <= 1'b0;
        in_ch.pattern_index <= '0;
        in_ch.symbol        <= '0;
        foreach (pattern_shadow[i]) pattern_shadow[i] = '0;
        foreach (window_shadow[i]) window_shadow[i] = '0;
        seen_count  = '0;
        len_shadow  = 7'd1;
        kmax_shadow = 7'd0;
        want        = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole pattern store so no read ever hits an unwritten entry
        for (int i = 0; i < kmps_pkg::PATTERN_MAX; i++) begin
            it.op    = kmps_pkg::OP_PATTERN;
            it.first = i[0];
            it.idx   = kmps_pkg::IDX_W'(i);
            it.sym   = kmps_pkg::t_sym'($urandom);
            send_item(it, 1'b0, 1'b0, want);
        end

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            case (row.kind)
                ROW_LEN: write_reg(kmps_pkg::CFG_PATTERN_LENGTH, row.val);
                ROW_MAX: write_reg(kmps_pkg::CFG_MAX_MISMATCHES, row.val);
                default: begin
                    it.op      = (row.kind == ROW_PAT) ? kmps_pkg::OP_PATTERN
                                                       : kmps_pkg::OP_TEXT;
                    it.first   = row.first;
                    it.idx     = row.idx;
                    it.sym     = row.sym;
                    want.start = row.start;
                    want.cnt   = row.val;
                    send_item(it, row.kind inside {ROW_HIT, ROW_NONE}, row.kind == ROW_HIT,
                              want);
                end
            endcase
        end

        rand_base = items_sent;
        phase     = 0;
        while (items_sent - rand_base < RAND_ITEMS) begin
            budget = $urandom_range(40, 90);
            case ($urandom_range(0, 5))
                0:       kmax = 0;
                1:       kmax = 64;
                2:       kmax = 127;
                default: kmax = $urandom_range(0, 3);
            endcase
            case (phase)
                0: begin  // every window reports: fills the pipeline for the squeeze
                    plen   = $urandom_range(2, 6);
                    kmax   = 127;
                    budget = 120;
                end
                1: begin
                    plen   = kmps_pkg::PATTERN_MAX;
                    kmax   = $urandom_range(2, 64);
                    budget = 160;
                end
                2: begin
                    plen   = $urandom_range(kmps_pkg::PATTERN_MAX + 1, 127);
                    kmax   = 10;
                    budget = 160;
                end
                3: begin
                    plen   = 0;
                    budget = 30;
                end
                default: plen = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                            : $urandom_range(9, 40);
            endcase
            if (phase == 0) begin
                write_reg(kmps_pkg::CFG_PATTERN_LENGTH, kmps_pkg::CFG_DATA_W'(plen));
                squeeze_go = 1'b1;
            end
            run_phase(plen, kmax, budget);
            phase++;
        end

        in_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, bursts of steady ready, and one long hold-off
    initial begin : drain
        int on_len;
        int gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (squeeze_go && !squeeze_done) begin
                squeeze_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end else begin
                on_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
                out_ch.ready <= 1'b1;
                repeat (on_len) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : collect
        t_match got;
        t_match want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.start = out_ch.match_start;
            got.cnt   = out_ch.mismatch_count;
            if (pending_hits.size() == 0) begin
                log_mismatch("result with nothing pending", '0, got);
            end else begin
                want = pending_hits.pop_front();
                if (got.start !== want.start || got.cnt !== want.cnt)
                    log_mismatch("wrong match", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || i_cfg_we === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d quiet cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
